### src/ortho3_pkg.sv
// shared constants, widths and a helper function for the 3x3 orthonormalizer
package ortho3_pkg;

    localparam int RED_BITS   = 20;
    localparam int RW         = RED_BITS + 1;
    localparam int NW         = 2 * RW;
    localparam int PW         = NW + RW;
    localparam int WW         = 64;
    localparam int OUT_W      = 32;
    localparam int Q_W        = 31;
    localparam int FRAC_OUT   = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = Q_W;
    localparam int FRONT_LAT  = 7;
    localparam int UNIT_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS;

    typedef logic signed [RW-1:0] red_t;
    typedef logic signed [NW-1:0] cross_t;
    typedef logic signed [WW-1:0] wide_t;
    typedef logic signed [OUT_W-1:0] comp_t;

    // position of the highest set bit plus one, zero for zero
    function automatic logic [6:0] bit_len64(input logic [63:0] v);
        logic [6:0] bl;
        bl = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                bl = 7'(i + 1);
            end
        end
        return bl;
    endfunction

endpackage

### src/ortho3_ifs.sv
// channel interfaces: input matrix and output orthonormal basis
interface ortho3_in_if #(parameter int W = 32);
    logic valid;
    logic ready;
    logic signed [W-1:0] a_x, a_y, a_z;
    logic signed [W-1:0] b_x, b_y, b_z;
    logic signed [W-1:0] c_x, c_y, c_z;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface ortho3_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] ua_x, ua_y, ua_z;
    logic signed [31:0] ub_x, ub_y, ub_z;
    logic signed [31:0] uc_x, uc_y, uc_z;
    logic degenerate;
    modport source (output valid, ua_x, ua_y, ua_z, ub_x, ub_y, ub_z, uc_x, uc_y, uc_z,
                    degenerate, input ready);
    modport sink (input valid, ua_x, ua_y, ua_z, ub_x, ub_y, ub_z, uc_x, uc_y, uc_z,
                  degenerate, output ready);
endinterface

### src/ortho3_front.sv
// input reduction, cross products n = a x b, w = n x a and the sign of c.n
module ortho3_front #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  logic signed [W-1:0]    vin [9],
    output logic                   valid_out,
    output logic                   degen_out,
    output ortho3_pkg::red_t       a_out [3],
    output ortho3_pkg::cross_t     n_out [3],
    output ortho3_pkg::wide_t      w_out [3]
);
    import ortho3_pkg::*;

    logic [FRONT_LAT-1:0] v_reg;

    // stage 1: magnitudes
    logic [W-1:0]  mag_reg [9];
    logic          neg_reg [9];
    logic [W-1:0]  top_reg [3];
    // stage 2: reduced components
    red_t          r_reg [9];
    // stage 3: products for n
    logic signed [NW-1:0] p_reg [6];
    red_t          a3_reg [3];
    red_t          c3_reg [3];
    logic          az3_reg;
    // stage 4: n
    cross_t        n4_reg [3];
    red_t          a4_reg [3];
    red_t          c4_reg [3];
    logic          az4_reg;
    // stage 5: products for w and d
    logic signed [PW-1:0] wp_reg [6];
    logic signed [PW-1:0] dp_reg [3];
    cross_t        n5_reg [3];
    red_t          a5_reg [3];
    logic          az5_reg;
    logic          nz5_reg;
    // stage 6: w and d
    wide_t         w6_reg [3];
    wide_t         d6_reg;
    cross_t        n6_reg [3];
    red_t          a6_reg [3];
    logic          bad6_reg;
    // stage 7: outputs
    wide_t         w7_reg [3];
    cross_t        n7_reg [3];
    red_t          a7_reg [3];
    logic          degen7_reg;

    logic [W-1:0]  mag_next [9];
    red_t          r_next [9];
    logic [6:0]    bl_next [3];
    logic [6:0]    sh_next [3];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            mag_next[i] = vin[i][W-1] ? (~vin[i] + W'(1)) : vin[i];
        end
        for (int v = 0; v < 3; v++)
        begin
            bl_next[v] = bit_len64(64'(top_reg[v]));
            sh_next[v] = (bl_next[v] > 7'(RED_BITS)) ? (bl_next[v] - 7'(RED_BITS)) : 7'd0;
        end
        for (int i = 0; i < 9; i++)
        begin
            logic [RED_BITS-1:0] m;
            m = RED_BITS'(mag_reg[i] >> sh_next[i / 3]);
            r_next[i] = neg_reg[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[FRONT_LAT-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                mag_reg[i] <= mag_next[i];
                neg_reg[i] <= vin[i][W-1];
                r_reg[i]   <= r_next[i];
            end
            for (int v = 0; v < 3; v++)
            begin
                top_reg[v] <= mag_next[3*v] | mag_next[3*v+1] | mag_next[3*v+2];
            end

            p_reg[0] <= r_reg[1] * r_reg[5];
            p_reg[1] <= r_reg[2] * r_reg[4];
            p_reg[2] <= r_reg[2] * r_reg[3];
            p_reg[3] <= r_reg[0] * r_reg[5];
            p_reg[4] <= r_reg[0] * r_reg[4];
            p_reg[5] <= r_reg[1] * r_reg[3];
            for (int i = 0; i < 3; i++)
            begin
                a3_reg[i] <= r_reg[i];
                c3_reg[i] <= r_reg[6+i];
            end
            az3_reg <= (r_reg[0] == '0) && (r_reg[1] == '0) && (r_reg[2] == '0);

            n4_reg[0] <= p_reg[0] - p_reg[1];
            n4_reg[1] <= p_reg[2] - p_reg[3];
            n4_reg[2] <= p_reg[4] - p_reg[5];
            a4_reg  <= a3_reg;
            c4_reg  <= c3_reg;
            az4_reg <= az3_reg;

            wp_reg[0] <= n4_reg[1] * a4_reg[2];
            wp_reg[1] <= n4_reg[2] * a4_reg[1];
            wp_reg[2] <= n4_reg[2] * a4_reg[0];
            wp_reg[3] <= n4_reg[0] * a4_reg[2];
            wp_reg[4] <= n4_reg[0] * a4_reg[1];
            wp_reg[5] <= n4_reg[1] * a4_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i] <= c4_reg[i] * n4_reg[i];
            end
            n5_reg  <= n4_reg;
            a5_reg  <= a4_reg;
            az5_reg <= az4_reg;
            nz5_reg <= (n4_reg[0] == '0) && (n4_reg[1] == '0) && (n4_reg[2] == '0);

            w6_reg[0] <= WW'(wp_reg[0]) - WW'(wp_reg[1]);
            w6_reg[1] <= WW'(wp_reg[2]) - WW'(wp_reg[3]);
            w6_reg[2] <= WW'(wp_reg[4]) - WW'(wp_reg[5]);
            d6_reg    <= WW'(dp_reg[0]) + WW'(dp_reg[1]) + WW'(dp_reg[2]);
            n6_reg    <= n5_reg;
            a6_reg    <= a5_reg;
            bad6_reg  <= az5_reg | nz5_reg;

            w7_reg <= w6_reg;
            a7_reg <= a6_reg;
            for (int i = 0; i < 3; i++)
            begin
                // third direction follows the side of the plane that c lies on
                n7_reg[i] <= d6_reg[WW-1] ? -n6_reg[i] : n6_reg[i];
            end
            degen7_reg <= bad6_reg | (d6_reg == '0);
        end
    end

    assign valid_out = v_reg[FRONT_LAT-1];
    assign degen_out = degen7_reg;
    assign a_out     = a7_reg;
    assign n_out     = n7_reg;
    assign w_out     = w7_reg;

endmodule

### src/ortho3_isqrt.sv
// pipelined integer square root, one result bit per stage
module ortho3_isqrt #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [63:0]   x,
    input  logic [SW-1:0] side_in,
    output logic [31:0]   root,
    output logic [SW-1:0] side_out
);
    import ortho3_pkg::*;

    logic [63:0]   x_reg    [SQRT_STEPS];
    logic [63:0]   r_reg    [SQRT_STEPS];
    logic [SW-1:0] side_reg [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0]   xi;
            logic [63:0]   ri;
            logic [SW-1:0] si;
            logic [63:0]   trial;
            if (k == 0)
            begin : g_first
                assign xi = x;
                assign ri = '0;
                assign si = side_in;
            end
            else
            begin : g_rest
                assign xi = x_reg[k-1];
                assign ri = r_reg[k-1];
                assign si = side_reg[k-1];
            end
            assign trial = ri + BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (xi >= trial)
                    begin
                        x_reg[k] <= xi - trial;
                        r_reg[k] <= (ri >> 1) + BIT;
                    end
                    else
                    begin
                        x_reg[k] <= xi;
                        r_reg[k] <= ri >> 1;
                    end
                    side_reg[k] <= si;
                end
            end
        end
    endgenerate

    assign root     = r_reg[SQRT_STEPS-1][31:0];
    assign side_out = side_reg[SQRT_STEPS-1];

endmodule

### src/ortho3_div.sv
// pipelined restoring divider, one quotient bit per stage
module ortho3_div #(
    parameter int SW = 1
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [63:0]               num,
    input  logic [31:0]               den,
    input  logic [SW-1:0]             side_in,
    output logic [ortho3_pkg::Q_W-1:0] quo,
    output logic [SW-1:0]             side_out
);
    import ortho3_pkg::*;

    logic [63:0]    rem_reg  [DIV_STEPS];
    logic [31:0]    den_reg  [DIV_STEPS];
    logic [Q_W-1:0] q_reg    [DIV_STEPS];
    logic [SW-1:0]  side_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            localparam int J = DIV_STEPS - 1 - k;
            logic [63:0]    ri;
            logic [31:0]    di;
            logic [Q_W-1:0] qi;
            logic [SW-1:0]  si;
            logic [63:0]    dsh;
            if (k == 0)
            begin : g_first
                assign ri = num;
                assign di = den;
                assign qi = '0;
                assign si = side_in;
            end
            else
            begin : g_rest
                assign ri = rem_reg[k-1];
                assign di = den_reg[k-1];
                assign qi = q_reg[k-1];
                assign si = side_reg[k-1];
            end
            assign dsh = 64'(di) << J;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (ri >= dsh)
                    begin
                        rem_reg[k] <= ri - dsh;
                        q_reg[k]   <= qi | (Q_W'(1) << J);
                    end
                    else
                    begin
                        rem_reg[k] <= ri;
                        q_reg[k]   <= qi;
                    end
                    den_reg[k]  <= di;
                    side_reg[k] <= si;
                end
            end
        end
    endgenerate

    assign quo      = q_reg[DIV_STEPS-1];
    assign side_out = side_reg[DIV_STEPS-1];

endmodule

### src/ortho3_unit.sv
// scales one vector to unit length in Q2.30
module ortho3_unit #(
    parameter int VW = 64
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [VW-1:0]  vin [3],
    output ortho3_pkg::comp_t     uout [3]
);
    import ortho3_pkg::*;

    localparam int SIDE_W = 3 + 3 * Q_W;

    logic [VW-1:0]  mag_reg [3];
    logic           neg1_reg [3];
    logic [VW-1:0]  top_reg;
    logic [Q_W-1:0] nm2_reg [3];
    logic           neg2_reg [3];
    logic [61:0]    sq_reg [3];
    logic [Q_W-1:0] nm3_reg [3];
    logic           neg3_reg [3];
    logic [63:0]    sum_reg;
    logic [SIDE_W-1:0] side4_reg;
    logic [63:0]    num_reg [3];
    logic [31:0]    den_reg;
    logic           negn_reg [3];

    logic [6:0]       bl;
    logic [Q_W-1:0]   nm_next [3];
    logic [31:0]      len;
    logic [SIDE_W-1:0] side_sq;
    logic [Q_W-1:0]   quo [3];
    logic             negq [3];

    always_comb
    begin
        bl = bit_len64(64'(top_reg));
        for (int i = 0; i < 3; i++)
        begin
            logic [VW+Q_W-1:0] ext;
            logic [VW+Q_W-1:0] sh;
            ext = {{Q_W{1'b0}}, mag_reg[i]};
            // largest magnitude lands in [2^30, 2^31)
            if (bl > 7'(Q_W))
            begin
                sh = ext >> (bl - 7'(Q_W));
            end
            else
            begin
                sh = ext << (7'(Q_W) - bl);
            end
            nm_next[i] = sh[Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= vin[i][VW-1] ? (~vin[i] + VW'(1)) : vin[i];
                neg1_reg[i] <= vin[i][VW-1];
                nm2_reg[i]  <= nm_next[i];
                neg2_reg[i] <= neg1_reg[i];
                sq_reg[i]   <= nm2_reg[i] * nm2_reg[i];
                nm3_reg[i]  <= nm2_reg[i];
                neg3_reg[i] <= neg2_reg[i];
            end
            top_reg <= (vin[0][VW-1] ? (~vin[0] + VW'(1)) : vin[0])
                     | (vin[1][VW-1] ? (~vin[1] + VW'(1)) : vin[1])
                     | (vin[2][VW-1] ? (~vin[2] + VW'(1)) : vin[2]);
            sum_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            side4_reg <= {neg3_reg[0], neg3_reg[1], neg3_reg[2],
                          nm3_reg[0], nm3_reg[1], nm3_reg[2]};
            for (int i = 0; i < 3; i++)
            begin
                // round half away from zero
                num_reg[i]  <= 64'({side_sq[(2-i)*Q_W +: Q_W], FRAC_OUT'(0)}) + 64'(len >> 1);
                negn_reg[i] <= side_sq[SIDE_W-1-i];
            end
            den_reg <= len;
        end
    end

    ortho3_isqrt #(.SW(SIDE_W)) u_isqrt (
        .clk      (clk),
        .en       (en),
        .x        (sum_reg),
        .side_in  (side4_reg),
        .root     (len),
        .side_out (side_sq)
    );

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            ortho3_div #(.SW(1)) u_div (
                .clk      (clk),
                .en       (en),
                .num      (num_reg[g]),
                .den      (den_reg),
                .side_in  (negn_reg[g]),
                .quo      (quo[g]),
                .side_out (negq[g])
            );
            assign uout[g] = negq[g] ? -$signed({1'b0, quo[g]}) : $signed({1'b0, quo[g]});
        end
    endgenerate

endmodule

### src/orthonormalize_3x3_core.sv
// top level: Gram-Schmidt orthonormalization of a 3x3 matrix, fully pipelined
//
//  channel   role    payload
//  matrix    sink    a_x..c_z, IN_WIDTH-bit signed Q16.16 rows
//  basis     source  ua_x..uc_z Q2.30, degenerate flag
//
//  one transaction accepted per cycle unless the output register is held; from acceptance
//  to basis.valid a transaction passes 7 cross-product stages, 68 normalization stages set
//  by the 32-step square root and 31-step divider, and one output register
//  reset clears only the valid bits; no clearing pass
//  when the output register is held, the whole pipeline holds and matrix.ready drops
module orthonormalize_3x3_core #(
    parameter int IN_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ortho3_in_if.sink    matrix,
    ortho3_out_if.source basis
);
    import ortho3_pkg::*;

    logic                      en;
    logic signed [IN_WIDTH-1:0] vin [9];
    logic                      f_valid;
    logic                      f_degen;
    red_t                      f_a [3];
    cross_t                    f_n [3];
    wide_t                     f_w [3];
    comp_t                     ua [3];
    comp_t                     ub [3];
    comp_t                     uc [3];

    logic [UNIT_LAT-1:0] dv_reg;
    logic [UNIT_LAT-1:0] dd_reg;
    logic                valid_reg;
    logic                degen_reg;
    comp_t               res_reg [9];

    assign en = !valid_reg || basis.ready;
    assign matrix.ready = en;

    assign vin[0] = matrix.a_x;
    assign vin[1] = matrix.a_y;
    assign vin[2] = matrix.a_z;
    assign vin[3] = matrix.b_x;
    assign vin[4] = matrix.b_y;
    assign vin[5] = matrix.b_z;
    assign vin[6] = matrix.c_x;
    assign vin[7] = matrix.c_y;
    assign vin[8] = matrix.c_z;

    ortho3_front #(.W(IN_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (matrix.valid),
        .vin       (vin),
        .valid_out (f_valid),
        .degen_out (f_degen),
        .a_out     (f_a),
        .n_out     (f_n),
        .w_out     (f_w)
    );

    ortho3_unit #(.VW(RW)) u_unit_a (.clk(clk), .en(en), .vin(f_a), .uout(ua));
    ortho3_unit #(.VW(WW)) u_unit_b (.clk(clk), .en(en), .vin(f_w), .uout(ub));
    ortho3_unit #(.VW(NW)) u_unit_c (.clk(clk), .en(en), .vin(f_n), .uout(uc));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg    <= {dv_reg[UNIT_LAT-2:0], f_valid};
            valid_reg <= dv_reg[UNIT_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg    <= {dd_reg[UNIT_LAT-2:0], f_degen};
            degen_reg <= dd_reg[UNIT_LAT-1];
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i]   <= dd_reg[UNIT_LAT-1] ? '0 : ua[i];
                res_reg[3+i] <= dd_reg[UNIT_LAT-1] ? '0 : ub[i];
                res_reg[6+i] <= dd_reg[UNIT_LAT-1] ? '0 : uc[i];
            end
        end
    end

    assign basis.valid      = valid_reg;
    assign basis.degenerate = degen_reg;
    assign basis.ua_x = res_reg[0];
    assign basis.ua_y = res_reg[1];
    assign basis.ua_z = res_reg[2];
    assign basis.ub_x = res_reg[3];
    assign basis.ub_y = res_reg[4];
    assign basis.ub_z = res_reg[5];
    assign basis.uc_x = res_reg[6];
    assign basis.uc_y = res_reg[7];
    assign basis.uc_z = res_reg[8];

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        basis.valid && basis.degenerate |->
            basis.ua_x == 0 && basis.ub_y == 0 && basis.uc_z == 0)
        else $error("degenerate result carries nonzero components");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        basis.valid && !basis.degenerate |->
            basis.ua_x <= 32'sd1073741824 && basis.ua_x >= -32'sd1073741824 &&
            basis.ub_x <= 32'sd1073741824 && basis.ub_x >= -32'sd1073741824 &&
            basis.uc_x <= 32'sd1073741824 && basis.uc_x >= -32'sd1073741824)
        else $error("unit component beyond one");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_reg))
        else $error("pipeline moved during a stall");

endmodule

### bench/tb_ifs.sv
// the bench shares the channel interfaces compiled with the design sources

### bench/tb_top.sv
// testbench for orthonormalize_3x3_core: directed table plus random matrices vs a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ortho3_pkg::*;

    localparam int LAT       = 76;
    localparam int N_RANDOM  = 500;
    localparam int MAX_CYCLE = 200000;
    localparam int N_DIR     = 14;

    typedef struct {
        logic signed [31:0] m[9];
    } matrix_t;

    typedef struct {
        logic signed [31:0] u[9];
        logic               degen;
    } basis_t;

    logic clk;
    logic rst_n;
    int   cycle;
    int   errors;
    bit   sending_done;
    bit   long_hold;

    ortho3_in_if #(.W(32)) matrix_ch();
    ortho3_out_if          basis_ch();

    orthonormalize_3x3_core #(.IN_WIDTH(32)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .matrix (matrix_ch.sink),
        .basis  (basis_ch.source)
    );

    basis_t expected_bases[$];

    task automatic queue_basis(basis_t bs);
        expected_bases = {expected_bases, bs};
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic longint unsigned mag(longint x);
        return (x < 0) ? longint'(0) - x : x;
    endfunction

    // common right shift of magnitudes until all below 2^bits
    function automatic void reduce_vec(inout longint v[3], input int bits);
        longint unsigned top;
        int s;
        top = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (mag(v[i]) > top)
                top = mag(v[i]);
        end
        while ((top >> s) >= (64'd1 << bits))
            s++;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = (v[i] < 0) ? -longint'(mag(v[i]) >> s) : longint'(mag(v[i]) >> s);
        end
    endfunction

    function automatic void cross_vec(input longint x[3], input longint y[3],
                                      output longint r[3]);
        r[0] = x[1] * y[2] - x[2] * y[1];
        r[1] = x[2] * y[0] - x[0] * y[2];
        r[2] = x[0] * y[1] - x[1] * y[0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_vec(input longint v[3], output logic signed [31:0] u[3]);
        longint w[3];
        longint unsigned top, sum, len, m, q;
        int s;
        w = v;
        reduce_vec(w, 31);
        top = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (mag(w[i]) > top)
                top = mag(w[i]);
        end
        if (top == 0)
        begin
            u[0] = 0;
            u[1] = 0;
            u[2] = 0;
            return;
        end
        while ((top << s) < (64'd1 << FRAC_OUT))
            s++;
        for (int i = 0; i < 3; i++)
        begin
            m = mag(w[i]) << s;
            sum += m * m;
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag(w[i]) << s << FRAC_OUT) + (len >> 1)) / len;
            u[i] = (w[i] < 0) ? -32'(q) : 32'(q);
        end
    endfunction

    function automatic basis_t gram_schmidt(matrix_t mx);
        basis_t r;
        longint a[3], b[3], c[3], n[3], w[3], d;
        logic signed [31:0] t[3];
        for (int i = 0; i < 3; i++)
        begin
            a[i] = mx.m[i];
            b[i] = mx.m[3+i];
            c[i] = mx.m[6+i];
        end
        reduce_vec(a, RED_BITS);
        reduce_vec(b, RED_BITS);
        reduce_vec(c, RED_BITS);
        foreach (r.u[i])
            r.u[i] = 0;
        r.degen = 1'b1;
        if (a[0] == 0 && a[1] == 0 && a[2] == 0)
            return r;
        cross_vec(a, b, n);
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
            return r;
        d = c[0] * n[0] + c[1] * n[1] + c[2] * n[2];
        if (d == 0)
            return r;
        r.degen = 1'b0;
        cross_vec(n, a, w);
        unit_vec(a, t);
        for (int i = 0; i < 3; i++) r.u[i] = t[i];
        unit_vec(w, t);
        for (int i = 0; i < 3; i++) r.u[3+i] = t[i];
        if (d < 0)
            for (int i = 0; i < 3; i++) n[i] = -n[i];
        unit_vec(n, t);
        for (int i = 0; i < 3; i++) r.u[6+i] = t[i];
        return r;
    endfunction

    // directed rows; known_out marks rows whose result is typed in
    matrix_t dir_in[N_DIR];
    basis_t  dir_out[N_DIR];
    bit      known_out[N_DIR];

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] Q1   = 32'sh4000_0000;

    task automatic set_row(int k, logic signed [31:0] v[9], bit known,
                           logic signed [31:0] e[9], logic dg);
        foreach (v[i])
        begin
            dir_in[k].m[i]  = v[i];
            dir_out[k].u[i] = e[i];
        end
        dir_out[k].degen = dg;
        known_out[k] = known;
    endtask

    initial
    begin
        logic signed [31:0] z[9];
        z = '{default: 0};
        // zero first vector
        set_row(0, z, 1, z, 1);
        // identity
        set_row(1, '{ONE,0,0, 0,ONE,0, 0,0,ONE}, 1, '{Q1,0,0, 0,Q1,0, 0,0,Q1}, 0);
        // left-handed third row flips sign of n
        set_row(2, '{ONE,0,0, 0,ONE,0, 0,0,-ONE}, 1, '{Q1,0,0, 0,Q1,0, 0,0,-Q1}, 0);
        // second vector parallel to first
        set_row(3, '{ONE,ONE,0, -2*ONE,-2*ONE,0, 0,0,ONE}, 1, z, 1);
        // third vector in the plane
        set_row(4, '{ONE,0,0, ONE,ONE,0, 5*ONE,-3*ONE,0}, 1, z, 1);
        // extremes of the field range
        set_row(5, '{MAXV,0,0, 0,MAXV,0, 0,0,MAXV}, 1, '{Q1,0,0, 0,Q1,0, 0,0,Q1}, 0);
        set_row(6, '{MINV,0,0, 0,MINV,0, 0,0,MINV}, 0, z, 0);
        set_row(7, '{MAXV,MINV,MAXV, MINV,MAXV,MINV, MAXV,MAXV,MINV}, 0, z, 0);
        set_row(8, '{MINV,MINV,MINV, MAXV,MINV,1, -1,MAXV,0}, 0, z, 0);
        // smallest magnitudes
        set_row(9, '{1,0,0, 0,-1,0, 0,0,1}, 0, z, 0);
        set_row(10, '{-1,-1,-1, 1,-1,0, 1,1,-2}, 0, z, 0);
        // large nearly parallel, judged after reduction
        set_row(11, '{MAXV,MAXV,MAXV, MAXV,MAXV,MAXV-1, 0,0,ONE}, 0, z, 0);
        set_row(12, '{3*ONE,4*ONE,0, -ONE,2*ONE,7, 123,-456,789}, 0, z, 0);
        set_row(13, '{32'sh000f_ffff,0,0, 0,32'sh0010_0000,0, 0,0,32'sh0010_0001}, 0, z, 0);
    end

    function automatic matrix_t random_matrix();
        matrix_t mx;
        int mode;
        mode = $urandom_range(0, 9);
        foreach (mx.m[i])
        begin
            case (mode)
                0, 1, 2, 3: mx.m[i] = $urandom;
                4, 5:       mx.m[i] = $signed($urandom_range(0, 16'hffff)) - 32768;
                6:          mx.m[i] = $signed($urandom_range(0, 6)) - 3;
                7:          mx.m[i] = ($urandom_range(0, 1) ? MAXV : MINV)
                                      ^ 32'($urandom_range(0, 3));
                default:    mx.m[i] = $signed($urandom) >>> $urandom_range(0, 31);
            endcase
        end
        // sometimes force a degenerate relation
        case ($urandom_range(0, 11))
            0: for (int i = 0; i < 3; i++) mx.m[3+i] = mx.m[i];
            1: for (int i = 0; i < 3; i++) mx.m[6+i] = mx.m[i];
            2: for (int i = 0; i < 3; i++) mx.m[i] = 0;
            default: ;
        endcase
        return mx;
    endfunction

    function automatic bit idle_now(int c);
        // no idling in this early stretch
        if (c > 100 && c < 250)
            return 0;
        return $urandom_range(0, 99) < 7;
    endfunction

    task automatic send_matrix(matrix_t mx);
        while (idle_now(cycle))
        begin
            matrix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        matrix_ch.valid <= 1'b1;
        {matrix_ch.a_x, matrix_ch.a_y, matrix_ch.a_z} <= {mx.m[0], mx.m[1], mx.m[2]};
        {matrix_ch.b_x, matrix_ch.b_y, matrix_ch.b_z} <= {mx.m[3], mx.m[4], mx.m[5]};
        {matrix_ch.c_x, matrix_ch.c_y, matrix_ch.c_z} <= {mx.m[6], mx.m[7], mx.m[8]};
        do
            @(posedge clk);
        while (!matrix_ch.ready);
    endtask

    // sender
    initial
    begin
        matrix_t mx;
        basis_t  pb;
        matrix_ch.valid <= 1'b0;
        {matrix_ch.a_x, matrix_ch.a_y, matrix_ch.a_z} <= '0;
        {matrix_ch.b_x, matrix_ch.b_y, matrix_ch.b_z} <= '0;
        {matrix_ch.c_x, matrix_ch.c_y, matrix_ch.c_z} <= '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < N_DIR; k++)
        begin
            pb = gram_schmidt(dir_in[k]);
            if (known_out[k] && pb != dir_out[k])
            begin
                for (int i = 0; i < 9; i++)
                begin
                    if (pb.u[i] !== dir_out[k].u[i])
                        $display("%0t directed row %0d component %0d: expected %0d actual %0d",
                                 $time, k, i, dir_out[k].u[i], pb.u[i]);
                end
                if (pb.degen !== dir_out[k].degen)
                    $display("%0t directed row %0d degenerate: expected %0b actual %0b",
                             $time, k, dir_out[k].degen, pb.degen);
                errors++;
            end
            queue_basis(known_out[k] ? dir_out[k] : pb);
            send_matrix(dir_in[k]);
        end
        for (int k = 0; k < N_RANDOM; k++)
        begin
            mx = random_matrix();
            queue_basis(gram_schmidt(mx));
            send_matrix(mx);
        end
        matrix_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // long hold-off of the receiver, counted here, to back the pipeline up
    initial
    begin
        long_hold <= 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        long_hold <= 1'b1;
        repeat (4 * LAT) @(posedge clk);
        long_hold <= 1'b0;
    end

    // receiver
    initial
    begin
        basis_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            basis_ch.ready <= !long_hold && !idle_now(cycle);
        end
    end

    // basis checker
    always @(posedge clk)
    begin
        basis_t got, want;
        if (rst_n && basis_ch.valid && basis_ch.ready)
        begin
            got.u = '{basis_ch.ua_x, basis_ch.ua_y, basis_ch.ua_z,
                      basis_ch.ub_x, basis_ch.ub_y, basis_ch.ub_z,
                      basis_ch.uc_x, basis_ch.uc_y, basis_ch.uc_z};
            got.degen = basis_ch.degenerate;
            if (expected_bases.size() == 0)
            begin
                $display("%0t unexpected basis transaction", $time);
                errors++;
            end
            else
            begin
                want = expected_bases.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    if (got.u[i] !== want.u[i])
                    begin
                        $display("%0t component %0d: expected %0d actual %0d",
                                 $time, i, want.u[i], got.u[i]);
                        errors++;
                    end
                end
                if (got.degen !== want.degen)
                begin
                    $display("%0t degenerate: expected %0b actual %0b",
                             $time, want.degen, got.degen);
                    errors++;
                end
            end
        end
    end

    // cycle limit and end of run
    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle >= MAX_CYCLE)
            begin
                $display("Verification failed");
                $finish;
            end
            if (sending_done && expected_bases.size() == 0)
            begin
                repeat (LAT + 10) @(posedge clk);
                if (errors == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
                $finish;
            end
        end
    end
endmodule
